@@ rtl/mhpq_pkg.sv @@
// Package for the max-heap priority queue: fixed field widths, opcodes,
// controller states, datapath commands and the datapath status bundle.
// No dependencies.
package mhpq_pkg;

    // Fixed widths of the weight and task id ports
    localparam int WEIGHT_W  = 32;
    localparam int ID_PORT_W = 16;

    // Input opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_CHECK,
        ST_UP_CMP,
        ST_POP_LOAD,
        ST_DN_CHECK,
        ST_DN_CMP,
        ST_WRITE,
        ST_RESULT
    } ctrl_state_t;

    // One command per cycle from controller to datapath
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_POP_LOAD,
        CMD_UP_READ,
        CMD_UP_MOVE,
        CMD_DN_READ,
        CMD_DN_MOVE,
        CMD_WRITE_FINAL,
        CMD_RESULT
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic full;        // heap holds HEAP_CAPACITY entries
        logic empty;       // heap holds no entry
        logic at_root;     // hole is at the root
        logic parent_le;   // parent weight <= moving weight: keep rising
        logic leaf;        // hole has no child
        logic child_gt;    // chosen child strictly heavier: keep sinking
        logic out_free;    // result register can take a new beat
    } dp_status_t;

endpackage

@@ rtl/mhpq_ctrl.sv @@
// Controller of the max-heap priority queue: sequences accept, sift up,
// sift down, final write and result hand-off. Depends on mhpq_pkg.
module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_opcode,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and command
    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd = CMD_ACCEPT;
                    priority if (s_opcode == OP_INSERT && !status.full) begin
                        state_next = ST_UP_CHECK;
                    end else if (s_opcode == OP_POP && !status.empty) begin
                        state_next = ST_POP_LOAD;
                    end else begin
                        // dropped insert or pop on empty heap
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_UP_CHECK: begin
                if (status.at_root) begin
                    state_next = ST_WRITE;
                end else begin
                    cmd        = CMD_UP_READ;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                if (status.parent_le) begin
                    cmd        = CMD_UP_MOVE;
                    state_next = ST_UP_CHECK;
                end else begin
                    state_next = ST_WRITE;
                end
            end
            ST_POP_LOAD: begin
                cmd = CMD_POP_LOAD;
                // heap now empty: nothing left to sink
                state_next = status.empty ? ST_RESULT : ST_DN_CHECK;
            end
            ST_DN_CHECK: begin
                if (status.leaf) begin
                    state_next = ST_WRITE;
                end else begin
                    cmd        = CMD_DN_READ;
                    state_next = ST_DN_CMP;
                end
            end
            ST_DN_CMP: begin
                if (status.child_gt) begin
                    cmd        = CMD_DN_MOVE;
                    state_next = ST_DN_CHECK;
                end else begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd        = CMD_WRITE_FINAL;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd        = CMD_RESULT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/mhpq_dp.sv @@
// Datapath of the max-heap priority queue: heap store memory with one write
// and two registered read ports, hole position, entry count, result register.
// Depends on mhpq_pkg.
module mhpq_dp
    import mhpq_pkg::*;
#(
    parameter int HEAP_CAPACITY = 256,
    parameter int TASK_ID_BITS  = 16,
    parameter int CW            = $clog2(HEAP_CAPACITY + 1)
)(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  logic                 s_opcode,
    input  logic [ID_PORT_W-1:0] s_new_task_id,
    input  logic [WEIGHT_W-1:0]  s_new_weight,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_got_task,
    output logic [ID_PORT_W-1:0] m_out_task_id,
    output logic [WEIGHT_W-1:0]  m_out_weight,
    output logic                 m_insert_dropped,
    output logic [CW-1:0]        m_entries_held
);

    localparam int AW   = $clog2(HEAP_CAPACITY);
    localparam int IW   = AW + 2;
    localparam int ID_W = TASK_ID_BITS;
    localparam int EW   = ID_W + WEIGHT_W;

    // Heap store: {id, weight} per entry, not cleared
    logic [EW-1:0] heap_mem [HEAP_CAPACITY];

    logic [CW-1:0]       count_reg;
    logic [AW-1:0]       pos_reg;
    logic [EW-1:0]       mov_reg;
    logic [EW-1:0]       rd_a_reg;
    logic [EW-1:0]       rd_b_reg;
    logic                got_reg;
    logic                dropped_reg;
    logic [ID_W-1:0]     pop_id_reg;
    logic [WEIGHT_W-1:0] pop_wt_reg;

    logic                m_valid_reg;
    logic                m_got_task_reg;
    logic [ID_PORT_W-1:0] m_out_task_id_reg;
    logic [WEIGHT_W-1:0] m_out_weight_reg;
    logic                m_insert_dropped_reg;
    logic [CW-1:0]       m_entries_held_reg;

    logic                full;
    logic                empty;
    logic [AW-1:0]       parent_idx;
    logic [IW-1:0]       c_wide;
    logic [IW-1:0]       c1_wide;
    logic [IW-1:0]       cnt_wide;
    logic                right_ok;
    logic                take_b;
    logic [EW-1:0]       child_entry;
    logic [AW-1:0]       child_idx;
    logic [AW-1:0]       last_idx;
    logic [AW-1:0]       rd_a_addr;
    logic [AW-1:0]       rd_b_addr;
    logic                rd_en;
    logic                wr_en;
    logic [EW-1:0]       wr_data;
    logic [EW-1:0]       in_entry;

    // Index arithmetic around the hole
    assign full       = (count_reg == CW'(HEAP_CAPACITY));
    assign empty      = (count_reg == '0);
    assign parent_idx = (pos_reg - AW'(1)) >> 1;
    assign c_wide     = IW'({pos_reg, 1'b1});
    assign c1_wide    = c_wide + IW'(1);
    assign cnt_wide   = IW'(count_reg);
    assign right_ok   = (c1_wide < cnt_wide);
    assign last_idx   = AW'(count_reg - CW'(1));
    assign in_entry   = {ID_W'(s_new_task_id), s_new_weight};

    // Child choice: right only when strictly heavier than left
    assign take_b      = right_ok && (rd_b_reg[WEIGHT_W-1:0] > rd_a_reg[WEIGHT_W-1:0]);
    assign child_entry = take_b ? rd_b_reg : rd_a_reg;
    assign child_idx   = take_b ? AW'(c1_wide) : AW'(c_wide);

    // Status bundle
    always_comb begin
        status.full      = full;
        status.empty     = empty;
        status.at_root   = (pos_reg == '0);
        status.parent_le = !(mov_reg[WEIGHT_W-1:0] < rd_a_reg[WEIGHT_W-1:0]);
        status.leaf      = (c_wide >= cnt_wide);
        status.child_gt  = (child_entry[WEIGHT_W-1:0] > mov_reg[WEIGHT_W-1:0]);
        status.out_free  = !m_valid_reg || m_ready;
    end

    // Memory port control; every write goes to the hole
    always_comb begin
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        rd_a_addr = AW'(c_wide);
        rd_b_addr = AW'(c1_wide);
        wr_data   = mov_reg;
        unique case (cmd)
            CMD_ACCEPT: begin
                rd_en     = 1'b1;
                rd_a_addr = '0;
                rd_b_addr = last_idx;
            end
            CMD_UP_READ: begin
                rd_en     = 1'b1;
                rd_a_addr = parent_idx;
            end
            CMD_DN_READ: begin
                rd_en = 1'b1;
            end
            CMD_UP_MOVE: begin
                wr_en   = 1'b1;
                wr_data = rd_a_reg;
            end
            CMD_DN_MOVE: begin
                wr_en   = 1'b1;
                wr_data = child_entry;
            end
            CMD_WRITE_FINAL: begin
                wr_en = 1'b1;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Heap store
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            heap_mem[pos_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= heap_mem[rd_a_addr];
            rd_b_reg <= heap_mem[rd_b_addr];
        end
    end

    // Entry count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd == CMD_ACCEPT) begin
            if (s_opcode == OP_INSERT && !full) begin
                count_reg <= count_reg + CW'(1);
            end else if (s_opcode == OP_POP && !empty) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // Hole position, moving entry and pending result fields
    always_ff @(posedge aclk) begin
        unique case (cmd)
            CMD_ACCEPT: begin
                got_reg     <= 1'b0;
                pop_id_reg  <= '0;
                pop_wt_reg  <= '0;
                dropped_reg <= (s_opcode == OP_INSERT) && full;
                mov_reg     <= in_entry;
                pos_reg     <= AW'(count_reg);
            end
            CMD_POP_LOAD: begin
                got_reg    <= 1'b1;
                pop_id_reg <= rd_a_reg[EW-1:WEIGHT_W];
                pop_wt_reg <= rd_a_reg[WEIGHT_W-1:0];
                mov_reg    <= rd_b_reg;
                pos_reg    <= '0;
            end
            CMD_UP_MOVE: begin
                pos_reg <= parent_idx;
            end
            CMD_DN_MOVE: begin
                pos_reg <= child_idx;
            end
            default: begin
                pos_reg <= pos_reg;
            end
        endcase
    end

    // Result beat valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd == CMD_RESULT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result beat payload
    always_ff @(posedge aclk) begin
        if (cmd == CMD_RESULT) begin
            m_got_task_reg       <= got_reg;
            m_out_task_id_reg    <= ID_PORT_W'(pop_id_reg);
            m_out_weight_reg     <= pop_wt_reg;
            m_insert_dropped_reg <= dropped_reg;
            m_entries_held_reg   <= count_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_got_task       = m_got_task_reg;
    assign m_out_task_id    = m_out_task_id_reg;
    assign m_out_weight     = m_out_weight_reg;
    assign m_insert_dropped = m_insert_dropped_reg;
    assign m_entries_held   = m_entries_held_reg;

endmodule

@@ rtl/max_heap_priority_queue.sv @@
// Max-heap priority queue top level: controller plus datapath, one item at a time.
// Per level the sift loop runs a check state (registered read), then a compare state
// (compare and hole write); the final write and result states follow it.
// Next accept the cycle after the result is registered; a result stall holds the accept.
// Reset clears count, controller and result valid only.
// Depends on mhpq_pkg, mhpq_ctrl, mhpq_dp.
module max_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int HEAP_CAPACITY = 256,
    parameter int TASK_ID_BITS  = 16,
    parameter int CW            = $clog2(HEAP_CAPACITY + 1)
)(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  logic [ID_PORT_W-1:0] s_new_task_id,
    input  logic [WEIGHT_W-1:0]  s_new_weight,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_got_task,
    output logic [ID_PORT_W-1:0] m_out_task_id,
    output logic [WEIGHT_W-1:0]  m_out_weight,
    output logic                 m_insert_dropped,
    output logic [CW-1:0]        m_entries_held
);

    dp_cmd_t    cmd;
    dp_status_t status;

    mhpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .status   (status),
        .cmd      (cmd)
    );

    mhpq_dp #(
        .HEAP_CAPACITY (HEAP_CAPACITY),
        .TASK_ID_BITS  (TASK_ID_BITS),
        .CW            (CW)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_opcode         (s_opcode),
        .s_new_task_id    (s_new_task_id),
        .s_new_weight     (s_new_weight),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_got_task       (m_got_task),
        .m_out_task_id    (m_out_task_id),
        .m_out_weight     (m_out_weight),
        .m_insert_dropped (m_insert_dropped),
        .m_entries_held   (m_entries_held)
    );

    // One item in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item accepted while another is in flight");

    // Result register is loaded only when free
    a_result_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == CMD_RESULT) |-> status.out_free)
        else $error("result beat overwritten");

    // A beat never reports both a popped entry and a dropped insert
    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_got_task && m_insert_dropped))
        else $error("result beat has both got_task and insert_dropped");

    // Count never exceeds capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_entries_held <= CW'(HEAP_CAPACITY)))
        else $error("entry count above capacity");

endmodule
